// ----- src/assert_macros.svh -----
// Assertion helpers for the RTL. Define ASSERT_OFF to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// The condition must never be true at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

// Whenever the antecedent holds, the consequent must hold in the same cycle.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`else

`define ASSERT_NEVER(label, clk, rst_n, cond, msg)
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ----- src/pse_pkg.sv -----
`timescale 1ns / 1ps

package pse_pkg;

    // Image geometry.
    localparam int                 SIDE_W     = 14;
    localparam logic [SIDE_W-1:0]  SIDE_LIMIT = 14'd16383;
    localparam int                 RAW_W      = 30;
    localparam int                 BLK_W      = 15;

    // Deflate stored blocks and zlib trailer.
    localparam logic [15:0] STORED_BLOCK_BYTES = 16'hFFFF;
    localparam logic [16:0] ADLER_MOD          = 17'd65521;

    // Chunk checksum.
    localparam logic [31:0] CRC_POLY = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

    // Most bytes that one pixel transfer may return.
    localparam logic [5:0] CAP_RESULTS = 6'd53;

    // Default depth of the queues.
    localparam int QUEUE_DEPTH = 2;

    // Configuration register indexes.
    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    // Byte positions inside the file head (signature up to the zlib header).
    localparam logic [5:0] POS_IHDR_TYPE = 6'd12;
    localparam logic [5:0] POS_WIDTH_HI  = 6'd18;
    localparam logic [5:0] POS_WIDTH_LO  = 6'd19;
    localparam logic [5:0] POS_HEIGHT_HI = 6'd22;
    localparam logic [5:0] POS_HEIGHT_LO = 6'd23;
    localparam logic [5:0] POS_IHDR_CRC  = 6'd29;
    localparam logic [5:0] POS_IDAT_LEN  = 6'd33;
    localparam logic [5:0] POS_IDAT_TYPE = 6'd37;
    localparam logic [5:0] POS_HDR_LAST  = 6'd42;

    // Byte positions inside the file tail (Adler-32 up to the IEND CRC).
    localparam logic [5:0] POS_ADLER     = 6'd0;
    localparam logic [5:0] POS_IDAT_CRC  = 6'd4;
    localparam logic [5:0] POS_IEND_TYPE = 6'd12;
    localparam logic [5:0] POS_IEND_CRC  = 6'd16;
    localparam logic [5:0] POS_FIN_LAST  = 6'd19;

    // Raw byte slots of one pixel.
    localparam logic [2:0] RI_FILTER = 3'd0;
    localparam logic [2:0] RI_RED    = 3'd1;
    localparam logic [2:0] RI_GREEN  = 3'd2;
    localparam logic [2:0] RI_BLUE   = 3'd3;
    localparam logic [2:0] RI_ALPHA  = 3'd4;

    // Stored block header bytes after the final flag.
    localparam logic [2:0] HB_LEN_LO  = 3'd1;
    localparam logic [2:0] HB_LEN_HI  = 3'd2;
    localparam logic [2:0] HB_NLEN_LO = 3'd3;
    localparam logic [2:0] HB_NLEN_HI = 3'd4;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } t_pixel;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       file_end;
    } t_result;

    typedef struct packed {
        logic [SIDE_W-1:0] cur_w;
        logic [SIDE_W-1:0] cur_h;
        logic [RAW_W-1:0]  raw;
        logic [31:0]       idat;
    } t_size;

    // One byte step of the reflected CRC-32.
    function automatic logic [31:0] crc_update(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'b0, b};
        for (int k = 0; k < 8; k++) begin
            c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
        end
        return c;
    endfunction

    // Fixed bytes of the file head; the variable fields read as zero here.
    function automatic logic [7:0] hdr_byte(input logic [5:0] idx);
        logic [7:0] b;
        case (idx)
            6'd0:    b = 8'h89;
            6'd1:    b = 8'h50;
            6'd2:    b = 8'h4E;
            6'd3:    b = 8'h47;
            6'd4:    b = 8'h0D;
            6'd5:    b = 8'h0A;
            6'd6:    b = 8'h1A;
            6'd7:    b = 8'h0A;
            6'd11:   b = 8'h0D;
            6'd12:   b = 8'h49;
            6'd13:   b = 8'h48;
            6'd14:   b = 8'h44;
            6'd15:   b = 8'h52;
            6'd24:   b = 8'h08;
            6'd25:   b = 8'h06;
            6'd37:   b = 8'h49;
            6'd38:   b = 8'h44;
            6'd39:   b = 8'h41;
            6'd40:   b = 8'h54;
            6'd41:   b = 8'h78;
            6'd42:   b = 8'h01;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // Fixed bytes of the file tail.
    function automatic logic [7:0] fin_byte(input logic [5:0] idx);
        logic [7:0] b;
        case (idx)
            6'd12:   b = 8'h49;
            6'd13:   b = 8'h45;
            6'd14:   b = 8'h4E;
            6'd15:   b = 8'h44;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// ----- src/png_stored_rgba_encoder_core.sv -----
`timescale 1ns / 1ps
// Channel    | Handshake                | Payload
// -----------+--------------------------+------------------------------------
// pixels in  | i_push / o_full          | i_pixel (red, green, blue, alpha)
// bytes out  | o_empty / i_pop          | o_result (out_byte, run_last, file_end)
// config     | i_cfg_valid / o_cfg_ready| i_cfg_index, i_cfg_data
//
// In the byte sequencer a pixel inside the image is taken from the pixel queue
// and then gives one output byte for each of its four channels, plus the row
// filter byte and the stored block header bytes where they fall.
// The first pixel of an image adds the size calculation (multiplier and block
// count) and 43 head bytes; the last pixel adds 20 tail bytes.
// Reset is synchronous; there is no clearing pass.
// A full output queue stalls the sequencer; the pixel queue keeps accepting until it is full.
`include "assert_macros.svh"

module png_stored_rgba_encoder_core #(
    parameter int QUEUE_DEPTH = pse_pkg::QUEUE_DEPTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    input  pse_pkg::t_pixel             i_pixel,
    output logic                        o_full,
    output logic                        o_empty,
    input  logic                        i_pop,
    output pse_pkg::t_result            o_result,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic                        i_cfg_index,
    input  logic [pse_pkg::SIDE_W-1:0]  i_cfg_data
);

    localparam int PIX_W = $bits(pse_pkg::t_pixel);
    localparam int RES_W = $bits(pse_pkg::t_result);

    logic [pse_pkg::SIDE_W-1:0] r_image_width;
    logic [pse_pkg::SIDE_W-1:0] r_image_height;
    logic [PIX_W-1:0]           w_tok_data;
    logic                       w_tok_empty;
    logic                       w_tok_pop;
    logic                       w_size_start;
    logic                       w_size_done;
    pse_pkg::t_size             w_size;
    logic                       w_out_push;
    logic                       w_out_full;
    pse_pkg::t_result           w_out;
    logic [RES_W-1:0]           w_res_data;

    // Configuration registers; a write is always taken.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= pse_pkg::SIDE_W'(1);
            r_image_height <= pse_pkg::SIDE_W'(1);
        end else if (i_cfg_valid) begin
            if (i_cfg_index == pse_pkg::CFG_WIDTH) begin
                r_image_width <= i_cfg_data;
            end else begin
                r_image_height <= i_cfg_data;
            end
        end
    end

    // Pixel queue between the input side and the sequencer.
    pse_fifo #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (PIX_W)
    ) u_pix_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_data  (i_pixel),
        .o_full  (o_full),
        .i_pop   (w_tok_pop),
        .o_data  (w_tok_data),
        .o_empty (w_tok_empty)
    );

    // Image size and IDAT length unit.
    pse_size u_size (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_size_start),
        .i_width  (r_image_width),
        .i_height (r_image_height),
        .o_done   (w_size_done),
        .o_size   (w_size)
    );

    // Byte sequencer.
    pse_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_tok_empty  (w_tok_empty),
        .i_tok        (pse_pkg::t_pixel'(w_tok_data)),
        .o_tok_pop    (w_tok_pop),
        .o_size_start (w_size_start),
        .i_size_done  (w_size_done),
        .i_size       (w_size),
        .i_out_full   (w_out_full),
        .o_out_push   (w_out_push),
        .o_out        (w_out)
    );

    // Output queue toward the byte consumer.
    pse_fifo #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (RES_W)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_out_push),
        .i_data  (w_out),
        .o_full  (w_out_full),
        .i_pop   (i_pop),
        .o_data  (w_res_data),
        .o_empty (o_empty)
    );

    assign o_result = pse_pkg::t_result'(w_res_data);

    // Checks on the internal hand-offs.
    `ASSERT_NEVER(a_out_overflow, i_clk, i_rst_n, w_out_push && w_out_full, "output overflow")
    `ASSERT_NEVER(a_tok_underflow, i_clk, i_rst_n, w_tok_pop && w_tok_empty, "pixel underflow")
    `ASSERT_IMPLY(a_end_is_last, i_clk, i_rst_n, !o_empty && o_result.file_end, o_result.run_last, "end not last")

endmodule

// ----- src/pse_fifo.sv -----
`timescale 1ns / 1ps

module pse_fifo #(
    parameter int DEPTH = pse_pkg::QUEUE_DEPTH,
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             w_push;
    logic             w_pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    // Storage write.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ----- src/pse_size.sv -----
`timescale 1ns / 1ps

module pse_size (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [pse_pkg::SIDE_W-1:0]      i_width,
    input  logic [pse_pkg::SIDE_W-1:0]      i_height,
    output logic                            o_done,
    output pse_pkg::t_size                  o_size
);

    logic [2:0]                     r_v;
    logic [pse_pkg::SIDE_W-1:0]     r_w;
    logic [pse_pkg::SIDE_W-1:0]     r_h;
    logic [pse_pkg::RAW_W-1:0]      r_raw;
    logic [pse_pkg::BLK_W-1:0]      r_blocks;
    logic [31:0]                    r_idat;
    logic [pse_pkg::SIDE_W-1:0]     w_q;
    logic [16:0]                    w_rem;
    logic [16:0]                    w_rem1;
    logic                           w_ge;

    function automatic logic [pse_pkg::SIDE_W-1:0] side_of(input logic [pse_pkg::SIDE_W-1:0] v);
        logic [pse_pkg::SIDE_W-1:0] s;
        if (v == '0) begin
            s = pse_pkg::SIDE_W'(1);
        end else if (v > pse_pkg::SIDE_LIMIT) begin
            s = pse_pkg::SIDE_LIMIT;
        end else begin
            s = v;
        end
        return s;
    endfunction

    // Block count: raw = q * 65536 + low = q * 65535 + (q + low), so one
    // compare and subtract finishes the quotient, and a nonzero rest rounds up.
    assign w_q    = r_raw[pse_pkg::RAW_W-1:16];
    assign w_rem  = {1'b0, r_raw[15:0]} + {3'b0, w_q};
    assign w_ge   = (w_rem >= {1'b0, pse_pkg::STORED_BLOCK_BYTES});
    assign w_rem1 = w_ge ? w_rem - {1'b0, pse_pkg::STORED_BLOCK_BYTES} : w_rem;

    // Stage valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[1:0], i_start};
        end
    end

    // Sizes are sampled once per image and then held.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_w <= side_of(i_width);
            r_h <= side_of(i_height);
        end
        if (r_v[0]) begin
            r_raw <= pse_pkg::RAW_W'({16'b0, r_h}) * pse_pkg::RAW_W'({r_w, 2'b01});
        end
        if (r_v[1]) begin
            r_blocks <= {1'b0, w_q} + pse_pkg::BLK_W'(w_ge) + pse_pkg::BLK_W'(w_rem1 != '0);
        end
        if (r_v[2]) begin
            r_idat <= 32'd6 + 32'({r_blocks, 2'b00}) + 32'(r_blocks) + 32'(r_raw);
        end
    end

    assign o_done       = r_v[2];
    assign o_size.cur_w = r_w;
    assign o_size.cur_h = r_h;
    assign o_size.raw   = r_raw;
    assign o_size.idat  = r_idat;

endmodule

// ----- src/pse_seq.sv -----
`timescale 1ns / 1ps

module pse_seq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_tok_empty,
    input  pse_pkg::t_pixel   i_tok,
    output logic              o_tok_pop,
    output logic              o_size_start,
    input  logic              i_size_done,
    input  pse_pkg::t_size    i_size,
    input  logic              i_out_full,
    output logic              o_out_push,
    output pse_pkg::t_result  o_out
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SIZE = 5'b00010,
        S_HDR  = 5'b00100,
        S_RAW  = 5'b01000,
        S_FIN  = 5'b10000
    } t_state;

    t_state                         r_state, n_state;
    logic                           r_hold, n_hold;
    logic                           r_seq, n_seq;
    logic [5:0]                     r_cnt, n_cnt;
    logic [5:0]                     r_idx, n_idx;
    logic [2:0]                     r_ri, n_ri;
    logic                           r_in_hdr, n_in_hdr;
    logic [2:0]                     r_hi, n_hi;
    logic [pse_pkg::SIDE_W-1:0]     r_col, n_col;
    logic [15:0]                    r_block_left, n_block_left;
    logic [pse_pkg::RAW_W-1:0]      r_raw_left, n_raw_left;
    logic [31:0]                    r_crc, n_crc;
    logic [15:0]                    r_adl, n_adl;
    logic [15:0]                    r_adh, n_adh;
    logic [31:0]                    r_word, n_word;
    pse_pkg::t_pixel                r_px, n_px;

    logic        w_emit_state;
    logic        w_emit;
    logic [7:0]  w_byte;
    logic        w_type_start;
    logic        w_crc_first;
    logic        w_nat_last;
    logic        w_file_end;
    logic        w_last;
    logic        w_is_raw;
    logic        w_fin_blk;
    logic [15:0] w_len;
    logic [15:0] w_nlen;
    logic [16:0] w_adl_sum;
    logic [15:0] w_adl_new;
    logic [16:0] w_adh_sum;
    logic [15:0] w_adh_new;
    logic [1:0]  w_k;

    function automatic logic [7:0] be32_byte(input logic [31:0] v, input logic [1:0] k);
        logic [7:0] b;
        case (k)
            2'd0:    b = v[31:24];
            2'd1:    b = v[23:16];
            2'd2:    b = v[15:8];
            default: b = v[7:0];
        endcase
        return b;
    endfunction

    assign w_emit_state = (r_state == S_HDR) || (r_state == S_RAW) || (r_state == S_FIN);
    assign w_emit       = w_emit_state && !r_hold && !i_out_full;
    assign o_tok_pop    = !i_tok_empty && ((r_state == S_IDLE) || (w_emit_state && r_hold));
    assign o_size_start = (r_state == S_IDLE) && !i_tok_empty && !r_seq;

    // Stored block header fields.
    assign w_fin_blk = (r_raw_left <= pse_pkg::RAW_W'(pse_pkg::STORED_BLOCK_BYTES));
    assign w_len     = w_fin_blk ? r_raw_left[15:0] : pse_pkg::STORED_BLOCK_BYTES;
    assign w_nlen    = ~w_len;

    // Byte selection for the current position.
    always_comb begin
        w_byte       = 8'h00;
        w_type_start = 1'b0;
        w_crc_first  = 1'b0;
        w_nat_last   = 1'b0;
        w_file_end   = 1'b0;
        w_is_raw     = 1'b0;
        w_k          = 2'd0;
        case (r_state)
            S_HDR: begin
                w_byte       = pse_pkg::hdr_byte(r_idx);
                w_type_start = (r_idx == pse_pkg::POS_IHDR_TYPE) ||
                               (r_idx == pse_pkg::POS_IDAT_TYPE);
                if (r_idx == pse_pkg::POS_WIDTH_HI) begin
                    w_byte = {2'b00, i_size.cur_w[13:8]};
                end else if (r_idx == pse_pkg::POS_WIDTH_LO) begin
                    w_byte = i_size.cur_w[7:0];
                end else if (r_idx == pse_pkg::POS_HEIGHT_HI) begin
                    w_byte = {2'b00, i_size.cur_h[13:8]};
                end else if (r_idx == pse_pkg::POS_HEIGHT_LO) begin
                    w_byte = i_size.cur_h[7:0];
                end else if (r_idx >= pse_pkg::POS_IHDR_CRC && r_idx < pse_pkg::POS_IDAT_LEN) begin
                    w_k         = 2'(r_idx - pse_pkg::POS_IHDR_CRC);
                    w_crc_first = (w_k == 2'd0);
                    w_byte      = w_crc_first ? ~r_crc[31:24] : be32_byte(r_word, w_k);
                end else if (r_idx >= pse_pkg::POS_IDAT_LEN && r_idx < pse_pkg::POS_IDAT_TYPE) begin
                    w_k    = 2'(r_idx - pse_pkg::POS_IDAT_LEN);
                    w_byte = be32_byte(i_size.idat, w_k);
                end
            end
            S_RAW: begin
                if (r_in_hdr) begin
                    case (r_hi)
                        pse_pkg::HB_LEN_LO:  w_byte = w_len[7:0];
                        pse_pkg::HB_LEN_HI:  w_byte = w_len[15:8];
                        pse_pkg::HB_NLEN_LO: w_byte = w_nlen[7:0];
                        default:             w_byte = w_nlen[15:8];
                    endcase
                end else if (r_block_left == '0) begin
                    w_byte = {7'b0, w_fin_blk};
                end else begin
                    w_is_raw = 1'b1;
                    case (r_ri)
                        pse_pkg::RI_FILTER: w_byte = 8'h00;
                        pse_pkg::RI_RED:    w_byte = r_px.red;
                        pse_pkg::RI_GREEN:  w_byte = r_px.green;
                        pse_pkg::RI_BLUE:   w_byte = r_px.blue;
                        default:            w_byte = r_px.alpha;
                    endcase
                    w_nat_last = (r_ri == pse_pkg::RI_ALPHA) &&
                                 (r_raw_left != pse_pkg::RAW_W'(1));
                end
            end
            S_FIN: begin
                w_byte       = pse_pkg::fin_byte(r_idx);
                w_type_start = (r_idx == pse_pkg::POS_IEND_TYPE);
                w_nat_last   = (r_idx == pse_pkg::POS_FIN_LAST);
                w_file_end   = w_nat_last;
                if (r_idx < pse_pkg::POS_IDAT_CRC) begin
                    w_k    = 2'(r_idx - pse_pkg::POS_ADLER);
                    w_byte = be32_byte({r_adh, r_adl}, w_k);
                end else if (r_idx < pse_pkg::POS_IDAT_CRC + 6'd4) begin
                    w_k         = 2'(r_idx - pse_pkg::POS_IDAT_CRC);
                    w_crc_first = (w_k == 2'd0);
                    w_byte      = w_crc_first ? ~r_crc[31:24] : be32_byte(r_word, w_k);
                end else if (r_idx >= pse_pkg::POS_IEND_CRC) begin
                    w_k         = 2'(r_idx - pse_pkg::POS_IEND_CRC);
                    w_crc_first = (w_k == 2'd0);
                    w_byte      = w_crc_first ? ~r_crc[31:24] : be32_byte(r_word, w_k);
                end
            end
            default: begin
                w_byte = 8'h00;
            end
        endcase
    end

    // A transfer ends on its natural last byte or when the byte cap is reached.
    assign w_last = w_nat_last || (r_cnt == pse_pkg::CAP_RESULTS - 6'd1);

    // Running Adler-32 over the raw bytes.
    assign w_adl_sum = {1'b0, r_adl} + {9'b0, w_byte};
    assign w_adl_new = (w_adl_sum >= pse_pkg::ADLER_MOD) ?
                       16'(w_adl_sum - pse_pkg::ADLER_MOD) : w_adl_sum[15:0];
    assign w_adh_sum = {1'b0, r_adh} + {1'b0, w_adl_new};
    assign w_adh_new = (w_adh_sum >= pse_pkg::ADLER_MOD) ?
                       16'(w_adh_sum - pse_pkg::ADLER_MOD) : w_adh_sum[15:0];

    assign o_out_push     = w_emit;
    assign o_out.out_byte = w_byte;
    assign o_out.run_last = w_last;
    assign o_out.file_end = w_file_end;

    // Next-state logic of the byte sequencer.
    always_comb begin
        n_state      = r_state;
        n_hold       = r_hold;
        n_seq        = r_seq;
        n_cnt        = r_cnt;
        n_idx        = r_idx;
        n_ri         = r_ri;
        n_in_hdr     = r_in_hdr;
        n_hi         = r_hi;
        n_col        = r_col;
        n_block_left = r_block_left;
        n_raw_left   = r_raw_left;
        n_crc        = r_crc;
        n_adl        = r_adl;
        n_adh        = r_adh;
        n_word       = r_word;
        n_px         = r_px;
        case (r_state)
            S_IDLE: begin
                if (!i_tok_empty) begin
                    n_px  = i_tok;
                    n_cnt = '0;
                    if (r_seq) begin
                        n_state  = S_RAW;
                        n_ri     = (r_col == '0) ? pse_pkg::RI_FILTER : pse_pkg::RI_RED;
                        n_in_hdr = 1'b0;
                    end else begin
                        n_state = S_SIZE;
                    end
                end
            end
            S_SIZE: begin
                if (i_size_done) begin
                    n_state      = S_HDR;
                    n_idx        = '0;
                    n_raw_left   = i_size.raw;
                    n_block_left = '0;
                    n_col        = '0;
                    n_adl        = 16'd1;
                    n_adh        = 16'd0;
                    n_seq        = 1'b1;
                end
            end
            S_HDR, S_RAW, S_FIN: begin
                if (r_hold) begin
                    // Bytes past the cap go out with the next pixel transfer.
                    if (!i_tok_empty) begin
                        n_hold = 1'b0;
                        n_cnt  = '0;
                    end
                end else if (!i_out_full) begin
                    n_cnt = r_cnt + 6'd1;
                    n_crc = pse_pkg::crc_update(w_type_start ? pse_pkg::CRC_INIT : r_crc, w_byte);
                    if (w_crc_first) begin
                        n_word = ~r_crc;
                    end
                    if (r_state == S_HDR) begin
                        if (r_idx == pse_pkg::POS_HDR_LAST) begin
                            n_state  = S_RAW;
                            n_ri     = pse_pkg::RI_FILTER;
                            n_in_hdr = 1'b0;
                        end else begin
                            n_idx = r_idx + 6'd1;
                        end
                    end else if (r_state == S_RAW) begin
                        if (r_in_hdr) begin
                            if (r_hi == pse_pkg::HB_NLEN_HI) begin
                                n_in_hdr     = 1'b0;
                                n_block_left = w_len;
                            end else begin
                                n_hi = r_hi + 3'd1;
                            end
                        end else if (!w_is_raw) begin
                            n_in_hdr = 1'b1;
                            n_hi     = pse_pkg::HB_LEN_LO;
                        end else begin
                            n_adl        = w_adl_new;
                            n_adh        = w_adh_new;
                            n_block_left = r_block_left - 16'd1;
                            n_raw_left   = r_raw_left - pse_pkg::RAW_W'(1);
                            if (r_ri == pse_pkg::RI_ALPHA) begin
                                n_col = (r_col + 1'b1 >= i_size.cur_w) ? '0 : r_col + 1'b1;
                                if (r_raw_left == pse_pkg::RAW_W'(1)) begin
                                    n_state = S_FIN;
                                    n_idx   = '0;
                                end else begin
                                    n_state = S_IDLE;
                                end
                            end else begin
                                n_ri = r_ri + 3'd1;
                            end
                        end
                    end else begin
                        if (r_idx == pse_pkg::POS_FIN_LAST) begin
                            n_state = S_IDLE;
                            n_seq   = 1'b0;
                            n_crc   = pse_pkg::CRC_INIT;
                            n_adl   = 16'd1;
                            n_adh   = 16'd0;
                        end else begin
                            n_idx = r_idx + 6'd1;
                        end
                    end
                    if (w_last && !w_nat_last) begin
                        n_hold = 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control and checksum registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_hold       <= 1'b0;
            r_seq        <= 1'b0;
            r_cnt        <= '0;
            r_idx        <= '0;
            r_ri         <= '0;
            r_in_hdr     <= 1'b0;
            r_hi         <= '0;
            r_col        <= '0;
            r_block_left <= '0;
            r_raw_left   <= '0;
            r_crc        <= pse_pkg::CRC_INIT;
            r_adl        <= 16'd1;
            r_adh        <= 16'd0;
        end else begin
            r_state      <= n_state;
            r_hold       <= n_hold;
            r_seq        <= n_seq;
            r_cnt        <= n_cnt;
            r_idx        <= n_idx;
            r_ri         <= n_ri;
            r_in_hdr     <= n_in_hdr;
            r_hi         <= n_hi;
            r_col        <= n_col;
            r_block_left <= n_block_left;
            r_raw_left   <= n_raw_left;
            r_crc        <= n_crc;
            r_adl        <= n_adl;
            r_adh        <= n_adh;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_word <= n_word;
        r_px   <= n_px;
    end

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps

// Expected PNG byte stream for each pixel transfer, and its checker.
class png_file_predictor;
    // Register copies and image state.
    bit [13:0]           cfg_w = 14'd1;
    bit [13:0]           cfg_h = 14'd1;
    bit                  in_image;
    int unsigned         col;
    int unsigned         cur_w;
    int unsigned         cur_h;
    int unsigned         block_left;
    int unsigned         raw_left;
    int unsigned         idat_len;
    bit [31:0]           crc = 32'hFFFFFFFF;
    int unsigned         adler_lo = 1;
    int unsigned         adler_hi;
    bit [7:0]            scratch[$];
    bit [7:0]            backlog[$];
    bit                  backlog_end;
    pse_pkg::t_result    expected_bytes[$];
    int                  errors;

    function void put(bit [7:0] b);
        bit [31:0] c;
        c = crc ^ {24'b0, b};
        for (int k = 0; k < 8; k++) begin
            c = (c >> 1) ^ (pse_pkg::CRC_POLY & {32{c[0]}});
        end
        crc = c;
        scratch.insert(scratch.size(), b);
    endfunction

    function void put_word(bit [31:0] v);
        put(v[31:24]);
        put(v[23:16]);
        put(v[15:8]);
        put(v[7:0]);
    endfunction

    // A chunk type restarts the chunk checksum.
    function void put_type(bit [31:0] name);
        crc = pse_pkg::CRC_INIT;
        put_word(name);
    endfunction

    // One byte of the zlib payload, with a stored block header where one starts.
    function void put_raw(bit [7:0] v);
        bit          fin;
        int unsigned len;
        bit [15:0]   nlen;
        if (block_left == 0) begin
            fin  = raw_left <= 65535;
            len  = fin ? raw_left : 65535;
            nlen = ~len[15:0];
            put({7'b0, fin});
            put(len[7:0]);
            put(len[15:8]);
            put(nlen[7:0]);
            put(nlen[15:8]);
            block_left = len;
        end
        put(v);
        adler_lo += v;
        if (adler_lo >= 65521) adler_lo -= 65521;
        adler_hi += adler_lo;
        if (adler_hi >= 65521) adler_hi -= 65521;
        if (block_left > 0) block_left--;
        if (raw_left > 0) raw_left--;
    endfunction

    function void open_image();
        longint unsigned raw_len;
        longint unsigned blocks;
        bit [31:0]       c;
        cur_w      = (cfg_w == 0) ? 1 : cfg_w;
        cur_h      = (cfg_h == 0) ? 1 : cfg_h;
        raw_len    = longint'(cur_h) * (1 + 4 * longint'(cur_w));
        blocks     = (raw_len + 65534) / 65535;
        idat_len   = 32'(2 + 5 * blocks + raw_len + 4);
        raw_left   = 32'(raw_len);
        block_left = 0;
        col        = 0;
        adler_lo   = 1;
        adler_hi   = 0;
        put_word(32'h89504E47);
        put_word(32'h0D0A1A0A);
        put_word(32'd13);
        put_type("IHDR");
        put_word(cur_w);
        put_word(cur_h);
        put(8'd8);
        put(8'd6);
        put(8'd0);
        put(8'd0);
        put(8'd0);
        c = ~crc;
        put_word(c);
        put_word(idat_len);
        put_type("IDAT");
        put(8'h78);
        put(8'h01);
        in_image = 1'b1;
    endfunction

    function void close_image();
        bit [31:0] c;
        put_word({adler_hi[15:0], adler_lo[15:0]});
        c = ~crc;
        put_word(c);
        put_word(32'd0);
        put_type("IEND");
        c = ~crc;
        put_word(c);
        in_image = 1'b0;
        crc      = pse_pkg::CRC_INIT;
        adler_lo = 1;
        adler_hi = 0;
    endfunction

    // Queue up to the per-pixel cap from the given bytes.
    function void emit(ref bit [7:0] src[$], input bit mark_end);
        pse_pkg::t_result r;
        int               n;
        n = (src.size() < pse_pkg::CAP_RESULTS) ? src.size() : pse_pkg::CAP_RESULTS;
        for (int i = 0; i < n; i++) begin
            r.out_byte = src.pop_front();
            r.run_last = (i == n - 1);
            r.file_end = mark_end && (i == n - 1) && (src.size() == 0);
            expected_bytes.insert(expected_bytes.size(), r);
        end
    endfunction

    // An accepted pixel transfer.
    function void note_pixel(pse_pkg::t_pixel p);
        bit ends;
        // Pending bytes from the previous pixel go out first; this pixel is dropped.
        if (backlog.size() > 0) begin
            emit(backlog, backlog_end);
            if (backlog.size() == 0) backlog_end = 1'b0;
            return;
        end
        scratch.delete();
        if (!in_image) open_image();
        if (col == 0) put_raw(8'h00);
        put_raw(p.red);
        put_raw(p.green);
        put_raw(p.blue);
        put_raw(p.alpha);
        col++;
        if (col >= cur_w) col = 0;
        ends = (raw_left == 0);
        if (ends) close_image();
        emit(scratch, ends);
        if (scratch.size() > 0) begin
            backlog     = scratch;
            backlog_end = ends;
        end
    endfunction

    // An accepted byte transfer.
    function void check_byte(pse_pkg::t_result got);
        pse_pkg::t_result want;
        if (expected_bytes.size() == 0) begin
            $error("unexpected byte 0x%02h", got.out_byte);
            errors++;
            return;
        end
        want = expected_bytes.pop_front();
        if (got.out_byte !== want.out_byte) begin
            $error("out_byte: expected 0x%02h, got 0x%02h", want.out_byte, got.out_byte);
            errors++;
        end
        if (got.run_last !== want.run_last) begin
            $error("run_last: expected %0b, got %0b", want.run_last, got.run_last);
            errors++;
        end
        if (got.file_end !== want.file_end) begin
            $error("file_end: expected %0b, got %0b", want.file_end, got.file_end);
            errors++;
        end
    endfunction
endclass

module tb_top;

    localparam int STALL_LIMIT = 5000;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_push = 1'b0;
    pse_pkg::t_pixel            i_pixel = '0;
    logic                       o_full;
    logic                       o_empty;
    logic                       i_pop = 1'b0;
    pse_pkg::t_result           o_result;
    logic                       i_cfg_valid = 1'b0;
    logic                       o_cfg_ready;
    logic                       i_cfg_index = pse_pkg::CFG_WIDTH;
    logic [pse_pkg::SIDE_W-1:0] i_cfg_data = '0;

    png_file_predictor png_model = new();
    int                send_idle_pct;
    int                pop_stall_pct;
    int                quiet_cycles;

    png_stored_rgba_encoder_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (i_push),
        .i_pixel     (i_pixel),
        .o_full      (o_full),
        .o_empty     (o_empty),
        .i_pop       (i_pop),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // The byte side stalls at random.
    always @(negedge i_clk) begin
        i_pop <= i_rst_n && ($urandom_range(99) >= pop_stall_pct);
    end

    // Check every byte transfer and watch for a hung block.
    always @(posedge i_clk) begin
        if (i_rst_n && i_pop && !o_empty) png_model.check_byte(o_result);
        if ((i_push && !o_full) || (i_pop && !o_empty) || (i_cfg_valid && o_cfg_ready) ||
            !i_rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // One pixel transfer, with random idle cycles ahead of it.
    task automatic send_pixel(input pse_pkg::t_pixel p);
        while ($urandom_range(99) < send_idle_pct) begin
            i_push = 1'b0;
            @(negedge i_clk);
        end
        i_pixel = p;
        i_push  = 1'b1;
        forever begin
            @(posedge i_clk);
            if (!o_full) break;
        end
        png_model.note_pixel(p);
        @(negedge i_clk);
    endtask

    task automatic send_random_pixel();
        send_pixel(pse_pkg::t_pixel'($urandom));
    endtask

    // Wait until every expected byte has come out.
    task automatic wait_drained();
        while (png_model.expected_bytes.size() != 0) @(negedge i_clk);
    endtask

    // Register writes happen only once the block has gone quiet.
    task automatic write_size(input int unsigned w, input int unsigned h);
        i_push = 1'b0;
        wait_drained();
        repeat (60) @(negedge i_clk);
        for (int r = 0; r < 2; r++) begin
            i_cfg_valid = 1'b1;
            i_cfg_index = (r == 0) ? pse_pkg::CFG_WIDTH : pse_pkg::CFG_HEIGHT;
            i_cfg_data  = (r == 0) ? pse_pkg::SIDE_W'(w) : pse_pkg::SIDE_W'(h);
            forever begin
                @(posedge i_clk);
                if (o_cfg_ready) break;
            end
            if (r == 0) png_model.cfg_w = i_cfg_data;
            else png_model.cfg_h = i_cfg_data;
            @(negedge i_clk);
            i_cfg_valid = 1'b0;
        end
    endtask

    // A whole image of random pixels; a single-pixel image needs one more to drain.
    task automatic send_image(input int unsigned w, input int unsigned h);
        write_size(w, h);
        for (int unsigned n = 0; n < w * h; n++) send_random_pixel();
        if (w * h == 1) send_random_pixel();
    endtask

    initial begin
        int unsigned sent;
        send_idle_pct = 0;
        pop_stall_pct = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Zero sizes act as one; the single-pixel image spills into the next pixel.
        write_size(0, 0);
        send_pixel(32'h00000000);
        send_pixel(32'hFFFFFFFF);
        send_pixel(32'hFFFFFFFF);
        send_pixel(32'h00000000);

        // Small image with the sender waiting out every pixel.
        write_size(3, 2);
        for (int k = 0; k < 6; k++) begin
            send_pixel((k % 2) ? 32'hA5A5A5A5 : 32'h5A5A5A5A);
            i_push = 1'b0;
            wait_drained();
        end

        // Random small images across the idling phases.
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 3) ? 29 : 58) : 0;
            pop_stall_pct = (ph == 2) ? 58 : ((ph == 3) ? 29 : 0);
            sent = 0;
            while (sent < 20) begin
                int unsigned w;
                int unsigned h;
                w = ($urandom_range(5) == 0) ? 1 : $urandom_range(6, 1);
                h = ($urandom_range(5) == 0) ? 1 : $urandom_range(4, 1);
                send_image(w, h);
                sent += w * h;
            end
        end

        // Largest image: only the head and first pixels are checked.
        send_idle_pct = 0;
        pop_stall_pct = 0;
        write_size(pse_pkg::SIDE_LIMIT, pse_pkg::SIDE_LIMIT);
        for (int k = 0; k < 10; k++) send_random_pixel();
        i_push = 1'b0;

        wait_drained();
        repeat (100) @(posedge i_clk);
        if (png_model.expected_bytes.size() != 0) begin
            $error("%0d expected bytes never arrived", png_model.expected_bytes.size());
            png_model.errors++;
        end
        if (png_model.errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
